[hw/rtl/m4ct_pkg.sv]
`default_nettype none

package m4ct_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_SHIFT     = 12;
	localparam int FIELD_W        = 32;
	localparam int LANE_W         = 16;
	localparam int REG_W          = 64;
	localparam int ADDR_W         = 6;
	localparam int IDX_W          = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_COLUMN_ZERO  = 3'd0,
		REG_COLUMN_ONE   = 3'd1,
		REG_COLUMN_TWO   = 3'd2,
		REG_COLUMN_THREE = 3'd3,
		REG_TRANSPOSE    = 3'd4
	} reg_idx_t;

	localparam logic [REG_W-1:0] COLUMN_ZERO_RST  = 64'h0000_0000_0000_1000;
	localparam logic [REG_W-1:0] COLUMN_ONE_RST   = 64'h0000_0000_1000_0000;
	localparam logic [REG_W-1:0] COLUMN_TWO_RST   = 64'h0000_1000_0000_0000;
	localparam logic [REG_W-1:0] COLUMN_THREE_RST = 64'h1000_0000_0000_0000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] in_x;
		logic signed [FIELD_W-1:0] in_y;
		logic signed [FIELD_W-1:0] in_z;
		logic signed [FIELD_W-1:0] in_w;
	} vec_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic signed [FIELD_W-1:0] out_z;
		logic signed [FIELD_W-1:0] out_w;
		logic                      clipped;
	} res_item_t;

endpackage

`default_nettype wire

[hw/rtl/mat4_column_transform.sv]
// An accepted item passes through the multiply, pair add and final add stages, then is
// shifted and saturated into the output register.
// Throughput: one item per cycle while the output is not stalled; each stage advances
// when its successor has room, so a stall at the output backs up stage by stage without dropping items.
// Reset (arst_n low, asynchronous): all stages empty, matrix = identity, transpose off.
`default_nettype none

module mat4_column_transform
	import m4ct_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [REG_W-1:0]  pwdata,
	output logic      [REG_W-1:0]  prdata,
	output logic                   pready,
	input  wire logic              vec_valid,
	output logic                   vec_ready,
	input  wire vec_item_t         vec,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_item_t              res
);

	localparam int PROD_W  = COEF_WIDTH + DATA_WIDTH;
	localparam int SUM_MIN = DATA_WIDTH + FRAC_SHIFT + 1;
	localparam int SUM_W   = (PROD_W + 2 > SUM_MIN) ? PROD_W + 2 : SUM_MIN;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	// configuration
	logic [REG_W-1:0] col_q [4];
	logic             transpose_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0]    <= COLUMN_ZERO_RST;
			col_q[1]    <= COLUMN_ONE_RST;
			col_q[2]    <= COLUMN_TWO_RST;
			col_q[3]    <= COLUMN_THREE_RST;
			transpose_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COLUMN_ZERO:  col_q[0]    <= pwdata;
				REG_COLUMN_ONE:   col_q[1]    <= pwdata;
				REG_COLUMN_TWO:   col_q[2]    <= pwdata;
				REG_COLUMN_THREE: col_q[3]    <= pwdata;
				REG_TRANSPOSE:    transpose_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_COLUMN_ZERO:  prdata = col_q[0];
			REG_COLUMN_ONE:   prdata = col_q[1];
			REG_COLUMN_TWO:   prdata = col_q[2];
			REG_COLUMN_THREE: prdata = col_q[3];
			REG_TRANSPOSE:    prdata = {{(REG_W-1){1'b0}}, transpose_q};
			default:          prdata = '0;
		endcase
	end

	// coefficient matrix as seen by the datapath: coef[r][c] multiplies v[c] for row r
	logic signed [COEF_WIDTH-1:0] coef [4][4];
	logic signed [DATA_WIDTH-1:0] vin  [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (transpose_q) begin
					coef[r][c] = signed'(col_q[r][LANE_W*c +: COEF_WIDTH]);
				end else begin
					coef[r][c] = signed'(col_q[c][LANE_W*r +: COEF_WIDTH]);
				end
			end
		end
	end

	assign vin[0] = signed'(vec.in_x[DATA_WIDTH-1:0]);
	assign vin[1] = signed'(vec.in_y[DATA_WIDTH-1:0]);
	assign vin[2] = signed'(vec.in_z[DATA_WIDTH-1:0]);
	assign vin[3] = signed'(vec.in_w[DATA_WIDTH-1:0]);

	// stage flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4    = !v_s4 || res_ready;
	assign adv_s3    = !v_s3 || adv_s4;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign vec_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= vec_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: sixteen products
	logic signed [PROD_W-1:0] prod_s1 [4][4];

	always_ff @(posedge clk) begin
		if (adv_s1 && vec_valid) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= PROD_W'(coef[r][c] * vin[c]);
				end
			end
		end
	end

	// stage 2: pair sums
	logic signed [SUM_W-1:0] psum_s2 [4][2];

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			for (int r = 0; r < 4; r++) begin
				for (int h = 0; h < 2; h++) begin
					psum_s2[r][h] <= SUM_W'(prod_s1[r][2*h]) + SUM_W'(prod_s1[r][2*h+1]);
				end
			end
		end
	end

	// stage 3: full row sums
	logic signed [SUM_W-1:0] sum_s3 [4];

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			for (int r = 0; r < 4; r++) begin
				sum_s3[r] <= psum_s2[r][0] + psum_s2[r][1];
			end
		end
	end

	// stage 4: floor shift, saturate, into the output register
	logic signed [SUM_W-1:0]      shifted [4];
	logic signed [DATA_WIDTH-1:0] sat     [4];
	logic        [3:0]            clip;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			shifted[r] = sum_s3[r] >>> FRAC_SHIFT;
			if (shifted[r] > SAT_HI) begin
				sat[r]  = SAT_HI[DATA_WIDTH-1:0];
				clip[r] = 1'b1;
			end else if (shifted[r] < SAT_LO) begin
				sat[r]  = SAT_LO[DATA_WIDTH-1:0];
				clip[r] = 1'b1;
			end else begin
				sat[r]  = shifted[r][DATA_WIDTH-1:0];
				clip[r] = 1'b0;
			end
		end
	end

	res_item_t res_s4;

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			res_s4.out_x   <= FIELD_W'(sat[0]);
			res_s4.out_y   <= FIELD_W'(sat[1]);
			res_s4.out_z   <= FIELD_W'(sat[2]);
			res_s4.out_w   <= FIELD_W'(sat[3]);
			res_s4.clipped <= |clip;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_s4;

	// an empty first stage always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> vec_ready)
		else $error("input not ready with empty first stage");

	// an item in stage 1 that advances lands in stage 2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> v_s2)
		else $error("item lost between stage 1 and stage 2");

	// a blocked stage 3 keeps its item and data
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv_s3 |=> v_s3 && $stable(sum_s3[0]) && $stable(sum_s3[3]))
		else $error("stage 3 changed while stalled");

	// stage 4 only fills from a valid stage 3
	a_s4_source: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 && adv_s4 |=> !v_s4)
		else $error("output valid without a source item");

endmodule

`default_nettype wire
